// ----- sv/heater_status_frame_parser_unit_assert.svh -----
// Assertion macros for the heater status frame parser checker.
`ifndef HEATER_STATUS_FRAME_PARSER_UNIT_ASSERT_SVH
`define HEATER_STATUS_FRAME_PARSER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define HSFP_ASSERT_NEVER(label, cond, msg) \
  `HSFP_ASSERT(label, !(cond), msg)

`endif

// ----- sv/hsfp_pkg.sv -----
// Package with the types, constants and CRC function of the heater status frame parser.
`default_nettype none

package hsfp_pkg;

  // Frame layout and length limits.
  localparam int unsigned HeadBytes   = 18;
  localparam int unsigned PosWidth    = 6;
  localparam int unsigned CrcSpan     = 31;
  localparam int unsigned CrcSubLow   = 29;
  localparam int unsigned CrcSubHigh  = 30;
  localparam int unsigned MinLen      = 8;
  localparam int unsigned BasicLen    = 18;
  localparam int unsigned ExtendedLen = 32;

  localparam logic [PosWidth-1:0] PosMax = 6'd63;

  // Byte codes of the frame.
  localparam logic [7:0] HeaderByte  = 8'hAA;
  localparam logic [7:0] ModeBasic   = 8'h55;
  localparam logic [7:0] ModeVariant = 8'h66;
  localparam logic [7:0] ModeExt     = 8'h88;

  // Modbus CRC16 constants.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    FS_ACCEPTED     = 3'd0,
    FS_TOO_SHORT    = 3'd1,
    FS_BAD_HEADER   = 3'd2,
    FS_UNKNOWN      = 3'd3,
    FS_CRC_MISMATCH = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    LM_NONE     = 2'd0,
    LM_BASIC    = 2'd1,
    LM_EXTENDED = 2'd2,
    LM_VARIANT  = 2'd3
  } link_mode_t;

  // View of the current frame as the verdict logic sees it.
  typedef struct packed {
    logic [PosWidth-1:0]       pos;
    byte_t [HeadBytes-1:0]     head;
    logic [15:0]               crc;
    logic [15:0]               tail_word;
  } frame_view_t;

  // One verdict.
  typedef struct packed {
    frame_status_t      status;
    link_mode_t         mode;
    logic               heater_on;
    byte_t              heater_state;
    byte_t              fault_code;
    byte_t              heater_stage;
    byte_t              power_level;
    logic [15:0]        altitude;
    logic [15:0]        supply_tenths;
    logic signed [15:0] case_temperature;
    logic signed [15:0] cabin_temperature;
  } verdict_t;

  // Reflected CRC16 update over one byte, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hsfp_if.sv -----
// Valid/ready channel interfaces for input bytes and frame verdicts.
`default_nettype none

interface hsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface hsfp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_status;
  logic [1:0]         link_mode;
  logic               heater_on;
  logic [7:0]         heater_state;
  logic [7:0]         fault_code;
  logic [7:0]         heater_stage;
  logic [7:0]         power_level;
  logic [15:0]        altitude;
  logic [15:0]        supply_tenths;
  logic signed [15:0] case_temperature;
  logic signed [15:0] cabin_temperature;

  modport source (
    output valid, output frame_status, output link_mode, output heater_on,
    output heater_state, output fault_code, output heater_stage, output power_level,
    output altitude, output supply_tenths, output case_temperature,
    output cabin_temperature, input ready
  );
  modport sink (
    input valid, input frame_status, input link_mode, input heater_on,
    input heater_state, input fault_code, input heater_stage, input power_level,
    input altitude, input supply_tenths, input case_temperature,
    input cabin_temperature, output ready
  );
endinterface

`default_nettype wire

// ----- sv/hsfp_capture.sv -----
// Frame capture: byte position, stored header and trailer bytes, running CRC.
`default_nettype none

module hsfp_capture (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire hsfp_pkg::byte_t      rx_byte,
  input  wire logic                 last,
  output hsfp_pkg::frame_view_t     view
);

  logic [hsfp_pkg::PosWidth-1:0] pos_r;
  logic [hsfp_pkg::PosWidth-1:0] pos_nxt;
  logic [15:0]                   crc_r;
  logic [15:0]                   crc_nxt;
  hsfp_pkg::byte_t               head_r [hsfp_pkg::HeadBytes];
  logic [15:0]                   tail_r;
  hsfp_pkg::byte_t               crc_in;

  // Bytes 29 and 30 enter the CRC as copies of bytes 2 and 3.
  always_comb begin
    if (pos_r == hsfp_pkg::PosWidth'(hsfp_pkg::CrcSubLow)) begin
      crc_in = head_r[2];
    end else if (pos_r == hsfp_pkg::PosWidth'(hsfp_pkg::CrcSubHigh)) begin
      crc_in = head_r[3];
    end else begin
      crc_in = rx_byte;
    end
  end

  // Position and CRC restart after the last byte of a frame.
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (step) begin
      if (last) begin
        pos_nxt = '0;
        crc_nxt = hsfp_pkg::CrcInit;
      end else begin
        if (pos_r != hsfp_pkg::PosMax) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (pos_r < hsfp_pkg::PosWidth'(hsfp_pkg::CrcSpan)) begin
          crc_nxt = hsfp_pkg::crc_byte(crc_r, crc_in);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= hsfp_pkg::CrcInit;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // Store the header bytes and the CRC word bytes at their positions.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < int'(hsfp_pkg::HeadBytes); i++) begin
        if (pos_r == hsfp_pkg::PosWidth'(i)) begin
          head_r[i] <= rx_byte;
        end
      end
      if (pos_r == hsfp_pkg::PosWidth'(hsfp_pkg::CrcSubLow)) begin
        tail_r[7:0] <= rx_byte;
      end
      if (pos_r == hsfp_pkg::PosWidth'(hsfp_pkg::CrcSubHigh)) begin
        tail_r[15:8] <= rx_byte;
      end
    end
  end

  // The byte now in hand overrides the stored copy at its own position.
  always_comb begin
    view.pos       = pos_r;
    view.crc       = crc_r;
    view.tail_word = tail_r;
    for (int i = 0; i < int'(hsfp_pkg::HeadBytes); i++) begin
      view.head[i] = (pos_r == hsfp_pkg::PosWidth'(i)) ? rx_byte : head_r[i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/heater_status_frame_parser_unit.sv -----
// Top level of the heater status frame parser: input register, verdict logic, result register.
// The result register takes the verdict when the frame's last byte leaves the input register.
// The parser takes one byte per cycle, as the capture stage folds a whole byte into the CRC at once;
// bytes keep flowing while a verdict waits; only a last byte stalls behind a held verdict.
// Reset clears both valid flags, the byte position and the accepted mode, and sets the CRC to
// 0xFFFF; stored frame bytes are not cleared.
`default_nettype none

module heater_status_frame_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsfp_in_if.sink    in_ch,
  hsfp_out_if.source out_ch
);

  logic                  a_valid_r;
  logic                  a_valid_nxt;
  hsfp_pkg::byte_t       a_byte_r;
  logic                  a_last_r;
  logic                  a_fire;
  logic                  in_xfer;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  hsfp_pkg::verdict_t    res_r;
  hsfp_pkg::verdict_t    res_nxt;
  hsfp_pkg::link_mode_t  mode_r;
  hsfp_pkg::link_mode_t  mode_nxt;

  hsfp_pkg::frame_view_t view;
  logic [15:0]           crc_swapped;

  // A byte leaves the input register unless it ends a frame and the result is held.
  assign a_fire      = a_valid_r && (!a_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || a_fire;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_xfer) begin
      a_valid_nxt = 1'b1;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_byte_r <= in_ch.rx_byte;
      a_last_r <= in_ch.end_of_frame;
    end
  end

  hsfp_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (a_fire),
    .rx_byte (a_byte_r),
    .last    (a_last_r),
    .view    (view)
  );

  assign crc_swapped = {view.crc[7:0], view.crc[15:8]};

  // Verdict on the frame that the byte in hand completes.
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = hsfp_pkg::FS_ACCEPTED;
    mode_nxt       = mode_r;
    if (view.pos < hsfp_pkg::PosWidth'(hsfp_pkg::MinLen - 1)) begin
      res_nxt.status = hsfp_pkg::FS_TOO_SHORT;
    end else if (view.head[0] != hsfp_pkg::HeaderByte) begin
      res_nxt.status = hsfp_pkg::FS_BAD_HEADER;
    end else if (view.head[1] == hsfp_pkg::ModeBasic &&
                 view.pos >= hsfp_pkg::PosWidth'(hsfp_pkg::BasicLen - 1)) begin
      mode_nxt                  = hsfp_pkg::LM_BASIC;
      res_nxt.heater_state      = view.head[3];
      res_nxt.fault_code        = view.head[4];
      res_nxt.heater_stage      = view.head[5];
      res_nxt.power_level       = view.head[9];
      res_nxt.altitude          = {view.head[7], view.head[6]};
      res_nxt.supply_tenths     = {view.head[12], view.head[11]};
      res_nxt.case_temperature  = signed'({view.head[14], view.head[13]});
      res_nxt.cabin_temperature = signed'({view.head[16], view.head[15]});
    end else if (view.head[1] == hsfp_pkg::ModeVariant &&
                 view.pos >= hsfp_pkg::PosWidth'(hsfp_pkg::BasicLen - 1)) begin
      mode_nxt             = hsfp_pkg::LM_VARIANT;
      res_nxt.heater_state = view.head[3];
      res_nxt.fault_code   = view.head[17];
      res_nxt.heater_stage = view.head[5];
    end else if (view.head[1] == hsfp_pkg::ModeExt &&
                 view.pos >= hsfp_pkg::PosWidth'(hsfp_pkg::ExtendedLen - 1)) begin
      if (crc_swapped != view.tail_word) begin
        res_nxt.status = hsfp_pkg::FS_CRC_MISMATCH;
      end else begin
        mode_nxt             = hsfp_pkg::LM_EXTENDED;
        res_nxt.heater_state = view.head[3];
        res_nxt.fault_code   = view.head[4];
        res_nxt.power_level  = view.head[9];
      end
    end else begin
      res_nxt.status = hsfp_pkg::FS_UNKNOWN;
    end
    res_nxt.mode      = mode_nxt;
    res_nxt.heater_on = (res_nxt.heater_state != '0);
  end

  // Result register, loaded when a last byte leaves the input register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_fire && a_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= hsfp_pkg::LM_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (a_fire && a_last_r) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_last_r) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel.
  assign out_ch.valid             = out_valid_r;
  assign out_ch.frame_status      = res_r.status;
  assign out_ch.link_mode         = res_r.mode;
  assign out_ch.heater_on         = res_r.heater_on;
  assign out_ch.heater_state      = res_r.heater_state;
  assign out_ch.fault_code        = res_r.fault_code;
  assign out_ch.heater_stage      = res_r.heater_stage;
  assign out_ch.power_level       = res_r.power_level;
  assign out_ch.altitude          = res_r.altitude;
  assign out_ch.supply_tenths     = res_r.supply_tenths;
  assign out_ch.case_temperature  = res_r.case_temperature;
  assign out_ch.cabin_temperature = res_r.cabin_temperature;

endmodule

`default_nettype wire

// ----- sv/hsfp_checker.sv -----
// Port-level checker for the heater status frame parser, bound to the top level.
`default_nettype none

`include "heater_status_frame_parser_unit_assert.svh"

module hsfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_frame_status,
  input wire logic [1:0]  out_link_mode,
  input wire logic        out_heater_on,
  input wire logic [7:0]  out_heater_state,
  input wire logic [7:0]  out_fault_code,
  input wire logic [7:0]  out_power_level
);

  // A held verdict keeps its status while it waits for a transfer.
  `HSFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_frame_status), "held verdict changed")

  // An accepted frame always leaves a protocol recorded.
  `HSFP_ASSERT_NEVER(a_accept_mode, out_valid && out_frame_status == hsfp_pkg::FS_ACCEPTED && out_link_mode == hsfp_pkg::LM_NONE, "accepted frame without a link mode")

  // A rejected frame reports no parsed fields.
  `HSFP_ASSERT_NEVER(a_reject_zero, out_valid && out_frame_status != hsfp_pkg::FS_ACCEPTED && (out_heater_state != 8'd0 || out_fault_code != 8'd0 || out_power_level != 8'd0), "rejected frame carries fields")

  // The running flag follows the running state byte.
  `HSFP_ASSERT(a_heater_on, out_valid |-> out_heater_on == (out_heater_state != 8'd0), "heater_on disagrees with heater_state")

endmodule

bind heater_status_frame_parser_unit hsfp_checker u_hsfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_frame_status  (out_ch.frame_status),
  .out_link_mode     (out_ch.link_mode),
  .out_heater_on     (out_ch.heater_on),
  .out_heater_state  (out_ch.heater_state),
  .out_fault_code    (out_ch.fault_code),
  .out_power_level   (out_ch.power_level)
);

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the heater status frame parser: directed and random frames, verdicts checked.
module tb;

  // Reading styles of the verdict receiver.
  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT} rx_style_t;

  localparam int unsigned RandomBytes = 1630;
  localparam int unsigned StallCap    = 12;

  // Tracks the parser state, predicts one verdict per frame and checks what comes out.
  class frame_verdict_board;
    hsfp_pkg::byte_t       frame_bytes[32];
    logic [5:0]            next_pos;
    logic [15:0]           running_crc;
    hsfp_pkg::link_mode_t  last_mode;
    hsfp_pkg::verdict_t    awaited_verdicts[$];
    int unsigned           mismatches;
    int unsigned           verdicts_seen;

    function new();
      next_pos    = '0;
      running_crc = hsfp_pkg::CrcInit;
      last_mode   = hsfp_pkg::LM_NONE;
      mismatches  = 0;
      verdicts_seen = 0;
    endfunction

    // Reflected CRC16 update over one byte.
    static function logic [15:0] crc_fold(logic [15:0] acc, hsfp_pkg::byte_t b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ hsfp_pkg::CrcPoly) : (c >> 1);
      return c;
    endfunction

    function logic [15:0] word_le(int unsigned i);
      return {frame_bytes[(i + 1) % 32], frame_bytes[i % 32]};
    endfunction

    // Notes one byte transfer; a last byte queues the verdict it causes.
    function void absorb_byte(hsfp_pkg::byte_t b, logic last);
      hsfp_pkg::verdict_t v;
      hsfp_pkg::byte_t    crc_in;
      int unsigned        len;
      if (next_pos < 32) frame_bytes[next_pos[4:0]] = b;
      if (next_pos < hsfp_pkg::CrcSpan) begin
        crc_in = b;
        if (next_pos == hsfp_pkg::CrcSubLow) crc_in = frame_bytes[2];
        else if (next_pos == hsfp_pkg::CrcSubHigh) crc_in = frame_bytes[3];
        running_crc = crc_fold(running_crc, crc_in);
      end
      len = int'(next_pos) + 1;
      if (next_pos != hsfp_pkg::PosMax) next_pos = next_pos + 1'b1;
      if (!last) return;

      v = '0;
      v.status = hsfp_pkg::FS_ACCEPTED;
      if (len < hsfp_pkg::MinLen) begin
        v.status = hsfp_pkg::FS_TOO_SHORT;
      end else if (frame_bytes[0] != hsfp_pkg::HeaderByte) begin
        v.status = hsfp_pkg::FS_BAD_HEADER;
      end else if (frame_bytes[1] == hsfp_pkg::ModeBasic && len >= hsfp_pkg::BasicLen) begin
        last_mode           = hsfp_pkg::LM_BASIC;
        v.heater_state      = frame_bytes[3];
        v.fault_code        = frame_bytes[4];
        v.heater_stage      = frame_bytes[5];
        v.power_level       = frame_bytes[9];
        v.altitude          = word_le(6);
        v.supply_tenths     = word_le(11);
        v.case_temperature  = word_le(13);
        v.cabin_temperature = word_le(15);
      end else if (frame_bytes[1] == hsfp_pkg::ModeVariant && len >= hsfp_pkg::BasicLen) begin
        last_mode      = hsfp_pkg::LM_VARIANT;
        v.heater_state = frame_bytes[3];
        v.fault_code   = frame_bytes[17];
        v.heater_stage = frame_bytes[5];
      end else if (frame_bytes[1] == hsfp_pkg::ModeExt && len >= hsfp_pkg::ExtendedLen) begin
        // The stored CRC word is little-endian, the running CRC is compared byte-swapped.
        if ({running_crc[7:0], running_crc[15:8]} != word_le(29)) begin
          v.status = hsfp_pkg::FS_CRC_MISMATCH;
        end else begin
          last_mode      = hsfp_pkg::LM_EXTENDED;
          v.heater_state = frame_bytes[3];
          v.fault_code   = frame_bytes[4];
          v.power_level  = frame_bytes[9];
        end
      end else begin
        v.status = hsfp_pkg::FS_UNKNOWN;
      end
      v.mode      = last_mode;
      v.heater_on = (v.heater_state != 8'h00);
      awaited_verdicts.push_back(v);
      next_pos    = '0;
      running_crc = hsfp_pkg::CrcInit;
    endfunction

    task report(string msg);
      $display("verdict %0d mismatch: %s", verdicts_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Checks one verdict transfer against the oldest prediction.
    task check_verdict(hsfp_pkg::verdict_t got);
      hsfp_pkg::verdict_t want;
      verdicts_seen++;
      if (awaited_verdicts.size() == 0) begin
        report("verdict with no frame pending");
        return;
      end
      want = awaited_verdicts.pop_front();
      compare_field("frame_status", got.status, want.status);
      compare_field("link_mode", got.mode, want.mode);
      compare_field("heater_on", got.heater_on, want.heater_on);
      compare_field("heater_state", got.heater_state, want.heater_state);
      compare_field("fault_code", got.fault_code, want.fault_code);
      compare_field("heater_stage", got.heater_stage, want.heater_stage);
      compare_field("power_level", got.power_level, want.power_level);
      compare_field("altitude", got.altitude, want.altitude);
      compare_field("supply_tenths", got.supply_tenths, want.supply_tenths);
      compare_field("case_temperature", got.case_temperature, want.case_temperature);
      compare_field("cabin_temperature", got.cabin_temperature, want.cabin_temperature);
    endtask
  endclass

  logic clk;
  logic rst_n;

  hsfp_in_if  in_ch ();
  hsfp_out_if out_ch ();

  heater_status_frame_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_verdict_board board = new();

  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned rx_phase_left;
  int unsigned stall_run;
  rx_style_t   rx_style;

  // Clock and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready = 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    rx_phase_left = 0;
    stall_run = 0;
    rx_style = RX_OPEN;
  end

  always #10 clk = ~clk;

  // Verdict receiver: phases of always ready, coin-flip ready and mostly stalled.
  always @(posedge clk) begin
    logic take;
    if (rx_phase_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_phase_left = $urandom_range(50, 400);
    end
    rx_phase_left--;
    case (rx_style)
      RX_OPEN: begin
        take = 1'b1;
      end
      RX_COIN: begin
        take = 1'($urandom_range(0, 1));
      end
      default: begin
        take = ($urandom_range(0, 3) == 0) || (stall_run >= StallCap);
      end
    endcase
    stall_run = take ? 0 : stall_run + 1;
    out_ch.ready <= take;
  end

  // Verdict monitor.
  always @(posedge clk) begin
    hsfp_pkg::verdict_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status            = hsfp_pkg::frame_status_t'(out_ch.frame_status);
      got.mode              = hsfp_pkg::link_mode_t'(out_ch.link_mode);
      got.heater_on         = out_ch.heater_on;
      got.heater_state      = out_ch.heater_state;
      got.fault_code        = out_ch.fault_code;
      got.heater_stage      = out_ch.heater_stage;
      got.power_level       = out_ch.power_level;
      got.altitude          = out_ch.altitude;
      got.supply_tenths     = out_ch.supply_tenths;
      got.case_temperature  = out_ch.case_temperature;
      got.cabin_temperature = out_ch.cabin_temperature;
      board.check_verdict(got);
    end
  end

  // Sends one byte; a new burst starts after a random gap, sometimes none.
  task automatic send_byte(hsfp_pkg::byte_t b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.rx_byte      <= b;
    in_ch.end_of_frame <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.absorb_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(ref hsfp_pkg::byte_t f[$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Random frame body with the given header and mode; optionally a valid CRC word.
  function automatic void build_frame(ref hsfp_pkg::byte_t f[$],
                                      input hsfp_pkg::byte_t header,
                                      input hsfp_pkg::byte_t mode,
                                      input int unsigned len, input bit fix_crc);
    logic [15:0] c;
    f.delete();
    repeat (len) f.push_back(hsfp_pkg::byte_t'($urandom));
    if (len > 0) f[0] = header;
    if (len > 1) f[1] = mode;
    if (fix_crc && len >= hsfp_pkg::CrcSpan) begin
      c = hsfp_pkg::CrcInit;
      for (int i = 0; i < hsfp_pkg::CrcSubLow; i++) c = frame_verdict_board::crc_fold(c, f[i]);
      c = frame_verdict_board::crc_fold(c, f[2]);
      c = frame_verdict_board::crc_fold(c, f[3]);
      f[hsfp_pkg::CrcSubLow]  = c[15:8];
      f[hsfp_pkg::CrcSubHigh] = c[7:0];
    end
  endfunction

  task automatic send_built(hsfp_pkg::byte_t header, hsfp_pkg::byte_t mode,
                            int unsigned len, bit fix_crc);
    hsfp_pkg::byte_t f[$];
    build_frame(f, header, mode, len, fix_crc);
    send_frame(f);
  endtask

  // Main sequence.
  initial begin
    hsfp_pkg::byte_t f[$];
    int unsigned     random_start;
    int unsigned     pick;
    hsfp_pkg::byte_t mode;
    hsfp_pkg::byte_t header;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: too short (single byte and seven bytes), bad header,
    // basic mode at field extremes, one byte short of basic.
    send_built(8'h00, 8'h00, 1, 1'b0);
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeBasic, 7, 1'b0);
    send_built(hsfp_pkg::ModeBasic, hsfp_pkg::ModeBasic, 8, 1'b0);
    build_frame(f, hsfp_pkg::HeaderByte, hsfp_pkg::ModeBasic, hsfp_pkg::BasicLen, 1'b0);
    f[3] = 8'hFF; f[4] = 8'h00; f[5] = 8'hFF; f[6] = 8'hFF; f[7] = 8'hFF; f[9] = 8'h00;
    f[11] = 8'h00; f[12] = 8'h00; f[13] = 8'h00; f[14] = 8'h80; f[15] = 8'hFF; f[16] = 8'h7F;
    send_frame(f);
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeBasic, 17, 1'b0);

    // Variant mode with an all-zero body: heater reported off.
    build_frame(f, hsfp_pkg::HeaderByte, hsfp_pkg::ModeVariant, hsfp_pkg::BasicLen, 1'b0);
    for (int i = 2; i < hsfp_pkg::BasicLen; i++) f[i] = 8'h00;
    send_frame(f);

    // Extended mode: good CRC, corrupted CRC, one byte short, and a long frame.
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt, hsfp_pkg::ExtendedLen, 1'b1);
    build_frame(f, hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt, hsfp_pkg::ExtendedLen, 1'b1);
    f[hsfp_pkg::CrcSubHigh] = ~f[hsfp_pkg::CrcSubHigh];
    send_frame(f);
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt, 31, 1'b0);
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt, 70, 1'b1);

    // Unknown mode bytes and a minimum-length frame of a known mode.
    send_built(hsfp_pkg::HeaderByte, 8'h77, 20, 1'b0);
    send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeBasic, hsfp_pkg::MinLen, 1'b0);
    build_frame(f, hsfp_pkg::HeaderByte, 8'hFF, hsfp_pkg::MinLen, 1'b0);
    for (int i = 2; i < hsfp_pkg::MinLen; i++) f[i] = 8'hFF;
    send_frame(f);

    // Random frames, mostly well formed with random content.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeBasic,
                   $urandom_range(hsfp_pkg::BasicLen, 26), 1'b0);
      end else if (pick < 50) begin
        send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeVariant,
                   $urandom_range(hsfp_pkg::BasicLen, 24), 1'b0);
      end else if (pick < 68) begin
        send_built(hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt,
                   $urandom_range(hsfp_pkg::ExtendedLen, 36), 1'b1);
      end else if (pick < 76) begin
        // One flipped bit somewhere in the CRC span.
        build_frame(f, hsfp_pkg::HeaderByte, hsfp_pkg::ModeExt,
                    $urandom_range(hsfp_pkg::ExtendedLen, 34), 1'b1);
        f[$urandom_range(2, 30)] ^= hsfp_pkg::byte_t'(1 << $urandom_range(0, 7));
        send_frame(f);
      end else if (pick < 80) begin
        // Long frame past the store, and from 64 bytes on past the position saturation.
        case ($urandom_range(0, 2))
          0: mode = hsfp_pkg::ModeBasic;
          1: mode = hsfp_pkg::ModeVariant;
          default: mode = hsfp_pkg::ModeExt;
        endcase
        send_built(hsfp_pkg::HeaderByte, mode, $urandom_range(60, 80), 1'b1);
      end else begin
        // Noise: random lengths, headers and mode bytes.
        header = ($urandom_range(0, 3) == 0) ? hsfp_pkg::byte_t'($urandom)
                                             : hsfp_pkg::HeaderByte;
        case ($urandom_range(0, 4))
          0: mode = hsfp_pkg::ModeBasic;
          1: mode = hsfp_pkg::ModeVariant;
          2: mode = hsfp_pkg::ModeExt;
          default: mode = hsfp_pkg::byte_t'($urandom);
        endcase
        send_built(header, mode, $urandom_range(1, 34), 1'($urandom_range(0, 1)));
      end
    end

    in_ch.valid <= 1'b0;
    while (board.awaited_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("heater_status_frame_parser_unit regression: pass");
    end else begin
      $display("heater_status_frame_parser_unit regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing verdicts.
  initial begin
    #10000000;
    $display("heater_status_frame_parser_unit regression: fail");
    $finish;
  end

endmodule
